// ===== src/dq_pkg.sv =====
`default_nettype none
package dq_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int ACTION_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 4;
  localparam int OCC_W      = 5;
  localparam int STATUS_W   = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage
`default_nettype wire

// ===== src/dq_ram.sv =====
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port with enable (data holds otherwise)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/double_ended_queue_core.sv =====
`default_nettype none
// Bounded double-ended queue on a ring buffer of CAPACITY entries.
// Input channel (in_valid/in_ready) carries one request: action, value and
// position. Actions: push front/back, pop front/back, read at a position
// counted from the front, clear. Output channel (out_valid/out_ready)
// returns exactly one result per request: read_value (zero unless a read
// succeeded), occupancy after the request, empty/full flags and a status
// (ok, overflow, underflow, out of range). Refused requests change nothing.
// Throughput: one request per cycle unless the receiver stalls. Head and
// count update at acceptance, and each request makes at most one access to
// the storage RAM, which has a registered read; a result passes the RAM read
// stage and then the output register, which drives out_valid.
// Reset (rst_n low, synchronous) empties the queue and drops any request
// in flight; storage contents are not cleared and no clearing pass runs.
// When the receiver stalls, the result waits in the output register, one
// more request waits in the read stage, and in_ready drops after that.
module double_ended_queue_core #(
  parameter int CAPACITY   = dq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dq_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [dq_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [dq_pkg::POSITION_W-1:0] in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [dq_pkg::VALUE_W-1:0]    out_read_value,
  output logic      [dq_pkg::OCC_W-1:0]      out_occupancy,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  output logic      [dq_pkg::STATUS_W-1:0]   out_status
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = ((CNT_W > dq_pkg::POSITION_W) ? CNT_W : dq_pkg::POSITION_W) + 1;
  localparam int VALUE_W = dq_pkg::VALUE_W;
  localparam int OCC_W   = dq_pkg::OCC_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

  // Ring state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Read stage
  logic                         s1_valid_r;
  logic                         s1_rd_r;
  logic [OCC_W-1:0]             s1_occ_r;
  logic                         s1_empty_r;
  logic                         s1_full_r;
  logic [dq_pkg::STATUS_W-1:0]  s1_status_r;

  // Output register
  logic                         out_valid_r;
  logic [VALUE_W-1:0]           out_read_value_r;
  logic [OCC_W-1:0]             out_occ_r;
  logic                         out_empty_r;
  logic                         out_full_r;
  logic [dq_pkg::STATUS_W-1:0]  out_status_r;

  logic                         advance;
  logic                         accept;
  logic                         is_full;
  logic                         is_empty;
  logic [SUM_W-1:0]             head_ext;
  logic [SUM_W-1:0]             back_sum;
  logic [SUM_W-1:0]             pos_sum;
  logic [SUM_W-1:0]             pos_ext;
  logic [SUM_W-1:0]             cnt_ext;
  logic [IDX_W-1:0]             back_idx;
  logic [IDX_W-1:0]             pos_idx;
  logic [IDX_W-1:0]             head_plus1;
  logic [IDX_W-1:0]             head_minus1;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic                         rd_en;
  logic [dq_pkg::STATUS_W-1:0]  status;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic [DATA_WIDTH-1:0]        rd_data;

  // Handshake: output register drains, read stage moves on, input enters
  assign advance = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept = in_valid && in_ready;

  assign is_full  = (count_r == CNT_CAP);
  assign is_empty = (count_r == '0);

  // Ring index arithmetic (operands at most CAPACITY, one conditional wrap)
  assign head_ext = SUM_W'(head_r);
  assign cnt_ext  = SUM_W'(count_r);
  assign pos_ext  = SUM_W'(in_position);
  assign back_sum = head_ext + cnt_ext;
  assign pos_sum  = head_ext + pos_ext;
  assign back_idx = (back_sum >= SUM_CAP) ? IDX_W'(back_sum - SUM_CAP) : IDX_W'(back_sum);
  assign pos_idx  = (pos_sum >= SUM_CAP) ? IDX_W'(pos_sum - SUM_CAP) : IDX_W'(pos_sum);
  assign head_plus1  = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign head_minus1 = (head_r == '0) ? IDX_LAST : head_r - 1'b1;

  assign wr_data = DATA_WIDTH'(in_value);

  // Request decode: next ring state, storage access and status
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = back_idx;
    rd_en     = 1'b0;
    status    = dq_pkg::ST_OK;
    case (in_action)
      dq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          status = dq_pkg::ST_OVERFLOW;
        end else begin
          head_nxt  = head_minus1;
          count_nxt = count_r + 1'b1;
          wr_en     = accept;
          wr_addr   = head_minus1;
        end
      end
      dq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          status = dq_pkg::ST_OVERFLOW;
        end else begin
          count_nxt = count_r + 1'b1;
          wr_en     = accept;
        end
      end
      dq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          status = dq_pkg::ST_UNDERFLOW;
        end else begin
          head_nxt  = head_plus1;
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          status = dq_pkg::ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::ACT_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = dq_pkg::ST_RANGE;
        end else begin
          rd_en = accept;
        end
      end
      dq_pkg::ACT_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Storage
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pos_idx),
    .rd_data (rd_data)
  );

  // Ring state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Read stage: holds the request while the registered RAM read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_rd_r     <= rd_en;
      s1_occ_r    <= OCC_W'(count_nxt);
      s1_empty_r  <= (count_nxt == '0);
      s1_full_r   <= (count_nxt == CNT_CAP);
      s1_status_r <= status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (advance && s1_valid_r) begin
      out_read_value_r <= s1_rd_r ? VALUE_W'(rd_data) : '0;
      out_occ_r        <= s1_occ_r;
      out_empty_r      <= s1_empty_r;
      out_full_r       <= s1_full_r;
      out_status_r     <= s1_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_occupancy  = out_occ_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CAP        = dq_pkg::CAPACITY_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 64;
  localparam int BLOCK_LEN  = 100;
  localparam int NUM_BLOCKS = 15;

  // Action codes the block must ignore
  localparam logic [dq_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [dq_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  // Random mix leanings
  localparam int LEAN_FILL  = 0;
  localparam int LEAN_DRAIN = 1;
  localparam int LEAN_EVEN  = 2;

  typedef struct packed {
    logic [dq_pkg::VALUE_W-1:0]  read_value;
    logic [dq_pkg::OCC_W-1:0]    occupancy;
    logic                        is_empty;
    logic                        is_full;
    logic [dq_pkg::STATUS_W-1:0] status;
  } dq_result_t;

  // Deque predictor plus queue of pending results
  class dq_scoreboard;
    logic [dq_pkg::VALUE_W-1:0] ring [CAP];
    int                         head;
    int                         count;
    dq_result_t                 want_q [$];
    int                         errors;
    int                         checked;
    int                         peak;
    int                         status_seen [4];

    function new();
      head    = 0;
      count   = 0;
      errors  = 0;
      checked = 0;
      peak    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Apply one accepted request to the predicted deque
    function void note_request(logic [dq_pkg::ACTION_W-1:0] act,
                               logic [dq_pkg::VALUE_W-1:0] val,
                               logic [dq_pkg::POSITION_W-1:0] pos);
      dq_result_t r;
      r        = '0;
      r.status = dq_pkg::ST_OK;
      case (act)
        dq_pkg::ACT_PUSH_FRONT: begin
          if (count >= CAP) begin
            r.status = dq_pkg::ST_OVERFLOW;
          end else begin
            head       = (head + CAP - 1) % CAP;
            ring[head] = val;
            count++;
          end
        end
        dq_pkg::ACT_PUSH_BACK: begin
          if (count >= CAP) begin
            r.status = dq_pkg::ST_OVERFLOW;
          end else begin
            ring[(head + count) % CAP] = val;
            count++;
          end
        end
        dq_pkg::ACT_POP_FRONT: begin
          if (count == 0) begin
            r.status = dq_pkg::ST_UNDERFLOW;
          end else begin
            head = (head + 1) % CAP;
            count--;
          end
        end
        dq_pkg::ACT_POP_BACK: begin
          if (count == 0) r.status = dq_pkg::ST_UNDERFLOW;
          else count--;
        end
        dq_pkg::ACT_READ: begin
          if (int'(pos) >= count) r.status = dq_pkg::ST_RANGE;
          else r.read_value = ring[(head + int'(pos)) % CAP];
        end
        dq_pkg::ACT_CLEAR: begin
          head  = 0;
          count = 0;
        end
        default: ;
      endcase
      r.occupancy = count[dq_pkg::OCC_W-1:0];
      r.is_empty  = (count == 0);
      r.is_full   = (count == CAP);
      if (count > peak) peak = count;
      status_seen[r.status]++;
      want_q.insert(want_q.size(), r);
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(dq_result_t got);
      dq_result_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result %p", $realtime, got);
        return;
      end
      want = want_q[0];
      want_q.delete(0);
      checked++;
      if (got.read_value !== want.read_value || got.occupancy !== want.occupancy ||
          got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch rd %h/%h occ %0d/%0d empty %b/%b full %b/%b st %0d/%0d",
                   $realtime, want.read_value, got.read_value, want.occupancy,
                   got.occupancy, want.is_empty, got.is_empty, want.is_full,
                   got.is_full, want.status, got.status);
      end
    endfunction
  endclass

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [dq_pkg::ACTION_W-1:0]   in_action   = dq_pkg::ACT_PUSH_FRONT;
  logic [dq_pkg::VALUE_W-1:0]    in_value    = '0;
  logic [dq_pkg::POSITION_W-1:0] in_position = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [dq_pkg::VALUE_W-1:0]    out_read_value;
  logic [dq_pkg::OCC_W-1:0]      out_occupancy;
  logic                          out_is_empty;
  logic                          out_is_full;
  logic [dq_pkg::STATUS_W-1:0]   out_status;

  dq_scoreboard sb = new();
  bit           quiet    = 1'b0;
  logic         hold_req = 1'b0;
  int           n_sent   = 0;
  int           cycles   = 0;

  always #4 clk = ~clk;

  double_ended_queue_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_status     (out_status)
  );

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[double_ended_queue_core] ERROR");
      $finish;
    end
  end

  // Result side: check on handshake, random backpressure, one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result({out_read_value, out_occupancy, out_is_empty, out_is_full,
                       out_status});
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Offer one request and wait for its handshake
  task automatic send_request(input logic [dq_pkg::ACTION_W-1:0] act,
                              input logic [dq_pkg::VALUE_W-1:0] val,
                              input logic [dq_pkg::POSITION_W-1:0] pos);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, val, pos);
    n_sent++;
  endtask

  // Random request, leaning toward filling, draining or neither
  task automatic random_request(input int lean);
    int                            r;
    int                            push_pct;
    logic [dq_pkg::ACTION_W-1:0]   act;
    logic [dq_pkg::VALUE_W-1:0]    val;
    logic [dq_pkg::POSITION_W-1:0] pos;
    r        = $urandom_range(0, 99);
    push_pct = (lean == LEAN_FILL) ? 75 : (lean == LEAN_DRAIN) ? 25 : 50;
    val      = $urandom();
    if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 1) ? '1 : '0;
    pos = dq_pkg::POSITION_W'($urandom_range(0, 15));
    if (r < 2) begin
      act = dq_pkg::ACT_CLEAR;
    end else if (r < 4) begin
      act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
    end else if (r < 24) begin
      act = dq_pkg::ACT_READ;
      // mostly in-range reads once something is stored
      if (sb.count > 0 && $urandom_range(0, 99) < 80)
        pos = dq_pkg::POSITION_W'($urandom_range(0, sb.count - 1));
    end else if ($urandom_range(0, 99) < push_pct) begin
      act = $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
    end else begin
      act = $urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
    end
    send_request(act, val, pos);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty corner cases, ignored codes, fill to full, refusals
    send_request(ACT_SPARE_6, '1, '1);
    send_request(ACT_SPARE_7, '0, '0);
    send_request(dq_pkg::ACT_POP_BACK, '0, '0);
    send_request(dq_pkg::ACT_READ, '0, '0);
    for (int i = 0; i < CAP; i++)
      send_request((i % 2) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_BACK,
                   (i % 4 == 0) ? 32'h0 : (i % 4 == 1) ? 32'hFFFF_FFFF : $urandom(), '0);
    send_request(dq_pkg::ACT_READ, '0, 4'd15);
    send_request(dq_pkg::ACT_READ, '0, 4'd0);
    send_request(dq_pkg::ACT_PUSH_FRONT, 32'h1234_5678, '0);
    send_request(dq_pkg::ACT_PUSH_BACK, 32'h8765_4321, '0);
    send_request(dq_pkg::ACT_POP_FRONT, '0, '0);
    send_request(dq_pkg::ACT_READ, '0, 4'd15);
    send_request(dq_pkg::ACT_POP_BACK, '0, '0);
    send_request(dq_pkg::ACT_CLEAR, '0, '0);
    send_request(dq_pkg::ACT_POP_FRONT, '0, '0);

    // Random blocks with changing mix, a quiet stretch, a hold-off and a drain
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      quiet = (blk == 3);
      if (blk == 5) hold_req <= 1'b1;
      if (blk == 8) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      repeat (BLOCK_LEN) random_request(blk % 3);
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests: ok %0d, overflow %0d, underflow %0d, range %0d",
             n_sent, sb.status_seen[dq_pkg::ST_OK], sb.status_seen[dq_pkg::ST_OVERFLOW],
             sb.status_seen[dq_pkg::ST_UNDERFLOW], sb.status_seen[dq_pkg::ST_RANGE]);
    $display("Checked %0d results, peak occupancy %0d, %0d mismatches",
             sb.checked, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[double_ended_queue_core] OK");
    end else begin
      $display("[double_ended_queue_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_core.f =====
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue_core.sv
verif/tb_top.sv
